[hdl/spf_pkg.sv]
// Shared constants, types and conversion functions for the socket peer text formatter.
`default_nettype none
package spf_pkg;

    localparam int unsigned NumSlots = 26;
    localparam int unsigned SlotW    = $clog2(NumSlots);
    localparam int unsigned V4First  = 5;

    localparam logic [SlotW-1:0] SlotLast  = SlotW'(NumSlots - 1);
    localparam logic [SlotW-1:0] SlotV4    = SlotW'(V4First);
    localparam logic [SlotW-1:0] SlotV6    = '0;

    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChHexBase = 8'h57;
    localparam logic [7:0] ChDot     = 8'h2e;
    localparam logic [7:0] ChColon   = 8'h3a;
    localparam logic [7:0] ChOpen    = 8'h5b;
    localparam logic [7:0] ChClose   = 8'h5d;

    localparam logic FamV4 = 1'b0;
    localparam logic FamV6 = 1'b1;

    // {bcd[19:0], binary[15:0]} working word of the port conversion
    typedef logic [35:0] t_port_dd;

    typedef struct packed {
        logic            req;
        logic [3:0][11:0] oct;
        logic [31:0]     w0;
        logic [31:0]     w3;
        t_port_dd        port;
    } t_conv;

    typedef struct packed {
        logic [NumSlots-1:0][7:0] chars;
        logic [NumSlots-1:0]      keep;
        logic                     v4;
    } t_slots;

    function automatic t_port_dd port_dd8(input t_port_dd s);
        t_port_dd r;
        r = s;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 5; j++) begin
                if (r[16 + 4 * j +: 4] >= 4'd5) begin
                    r[16 + 4 * j +: 4] = r[16 + 4 * j +: 4] + 4'd3;
                end
            end
            r = r << 1;
        end
        return r;
    endfunction

    function automatic logic [11:0] oct_bcd(input logic [7:0] v);
        logic [19:0] r;
        r = {12'd0, v};
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (r[8 + 4 * j +: 4] >= 4'd5) begin
                    r[8 + 4 * j +: 4] = r[8 + 4 * j +: 4] + 4'd3;
                end
            end
            r = r << 1;
        end
        return r[19:8];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (ChZero + {4'd0, n}) : (ChHexBase + {4'd0, n});
    endfunction

endpackage
`default_nettype wire

[hdl/socket_peer_text_formatter.sv]
// Top level of the socket peer text formatter.
// Each peer word becomes its text, one ASCII character per output word, tlast on the
// final character. A peer passes four register stages (input, octet and first port
// conversion half, second port conversion half, slot layout) and then the output
// serializer, which walks a fixed slot layout one slot per cycle while its output
// register is free: an IPv4 peer walks slots 5 to 25 and an IPv6 peer all 26, whatever
// the text length, since slots of suppressed leading zeros are walked without output.
// It takes the next peer as it steps the last slot; the front stages accept the
// following peers meanwhile. Input tuser carries the family: 0 IPv4, 1 IPv6.
`default_nettype none
module socket_peer_text_formatter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // [31:0] ipv4_address, [63:32] ipv6_first_word, [95:64] ipv6_last_word,
    // [111:96] peer_port
    input  wire logic [111:0]  i_s_axis_tdata,
    // [0] req_type
    input  wire logic          i_s_axis_tuser,
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // [7:0] text_char
    output logic [7:0]         o_m_axis_tdata,
    output logic               o_m_axis_tlast
);
    import spf_pkg::*;

    logic   conv_valid, conv_ready;
    t_conv  conv;
    logic   slot_valid, slot_ready;
    t_slots slots;

    spf_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_req   (i_s_axis_tuser),
        .i_a4    (i_s_axis_tdata[31:0]),
        .i_w0    (i_s_axis_tdata[63:32]),
        .i_w3    (i_s_axis_tdata[95:64]),
        .i_port  (i_s_axis_tdata[111:96]),
        .o_valid (conv_valid),
        .i_ready (conv_ready),
        .o_conv  (conv)
    );

    spf_slots u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (conv_valid),
        .o_ready (conv_ready),
        .i_conv  (conv),
        .o_valid (slot_valid),
        .i_ready (slot_ready),
        .o_slots (slots)
    );

    spf_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (slot_valid),
        .o_ready  (slot_ready),
        .i_slots  (slots),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

[hdl/spf_convert.sv]
// Input register and binary to decimal conversion of octets and port; the port conversion is split over two stages.
`default_nettype none
module spf_convert (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_req,
    input  wire logic [31:0]   i_a4,
    input  wire logic [31:0]   i_w0,
    input  wire logic [31:0]   i_w3,
    input  wire logic [15:0]   i_port,
    output logic               o_valid,
    input  wire logic          i_ready,
    output spf_pkg::t_conv     o_conv
);
    import spf_pkg::*;

    logic        r_v1, r_v2, r_v3;
    logic        r1_req;
    logic [31:0] r1_a4, r1_w0, r1_w3;
    logic [15:0] r1_port;
    t_conv       r_c2, r_c3, n_c2, n_c3;
    logic        en1, en2, en3;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_conv  = r_c3;

    always_comb begin
        n_c2.req  = r1_req;
        n_c2.w0   = r1_w0;
        n_c2.w3   = r1_w3;
        for (int k = 0; k < 4; k++) begin
            n_c2.oct[k] = oct_bcd(r1_a4[8 * k +: 8]);
        end
        n_c2.port = port_dd8({20'd0, r1_port});
        n_c3      = r_c2;
        n_c3.port = port_dd8(r_c2.port);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r1_req  <= i_req;
            r1_a4   <= i_a4;
            r1_w0   <= i_w0;
            r1_w3   <= i_w3;
            r1_port <= i_port;
        end
        if (en2 && r_v1) r_c2 <= n_c2;
        if (en3 && r_v2) r_c3 <= n_c3;
    end

endmodule
`default_nettype wire

[hdl/spf_slots.sv]
// Character slot builder: lays the text out on fixed slots with a keep mask.
`default_nettype none
module spf_slots (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  spf_pkg::t_conv     i_conv,
    output logic               o_valid,
    input  wire logic          i_ready,
    output spf_pkg::t_slots    o_slots
);
    import spf_pkg::*;

    logic        r_v;
    t_slots      r_s, n_s;
    logic        en;
    logic [19:0] pbcd;
    logic [11:0] oct;
    logic [3:0]  dig;
    logic        seen;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_slots = r_s;

    always_comb begin
        n_s.chars = '0;
        n_s.keep  = '0;
        n_s.v4    = (i_conv.req == FamV4);
        pbcd      = i_conv.port[35:16];
        oct       = '0;
        dig       = '0;
        seen      = 1'b0;
        if (i_conv.req == FamV6) begin
            n_s.chars[0]  = ChOpen;
            n_s.keep[0]   = 1'b1;
            for (int i = 0; i < 8; i++) begin
                n_s.chars[1 + i]  = hex_char(i_conv.w0[28 - 4 * i +: 4]);
                n_s.keep[1 + i]   = 1'b1;
                n_s.chars[11 + i] = hex_char(i_conv.w3[28 - 4 * i +: 4]);
                n_s.keep[11 + i]  = 1'b1;
            end
            n_s.chars[9]  = ChDot;
            n_s.chars[10] = ChDot;
            n_s.chars[19] = ChClose;
            n_s.chars[20] = ChColon;
            n_s.keep[9]   = 1'b1;
            n_s.keep[10]  = 1'b1;
            n_s.keep[19]  = 1'b1;
            n_s.keep[20]  = 1'b1;
        end else begin
            for (int k = 0; k < 4; k++) begin
                oct = i_conv.oct[3 - k];
                n_s.chars[5 + 4 * k] = ChZero + {4'd0, oct[11:8]};
                n_s.chars[6 + 4 * k] = ChZero + {4'd0, oct[7:4]};
                n_s.chars[7 + 4 * k] = ChZero + {4'd0, oct[3:0]};
                n_s.chars[8 + 4 * k] = (k == 3) ? ChColon : ChDot;
                n_s.keep[5 + 4 * k]  = (oct[11:8] != 4'd0);
                n_s.keep[6 + 4 * k]  = (oct[11:4] != 8'd0);
                n_s.keep[7 + 4 * k]  = 1'b1;
                n_s.keep[8 + 4 * k]  = 1'b1;
            end
        end
        for (int j = 0; j < 5; j++) begin
            dig = pbcd[16 - 4 * j +: 4];
            seen = seen || (dig != 4'd0);
            n_s.chars[21 + j] = ChZero + {4'd0, dig};
            n_s.keep[21 + j]  = seen || (j == 4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) r_s <= n_s;
    end

endmodule
`default_nettype wire

[hdl/spf_serial.sv]
// Slot walker and output register: emits one kept character per word.
`default_nettype none
module spf_serial (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  spf_pkg::t_slots    i_slots,
    output logic               o_tvalid,
    input  wire logic          i_tready,
    output logic [7:0]         o_tdata,
    output logic               o_tlast
);
    import spf_pkg::*;

    logic                     r_busy;
    logic [SlotW-1:0]         r_idx;
    logic [NumSlots-1:0][7:0] r_chars;
    logic [NumSlots-1:0]      r_keep;
    logic                     r_out_valid;
    logic [7:0]               r_out_char;
    logic                     r_out_last;
    logic                     out_free, step, done, load;

    assign out_free = !r_out_valid || i_tready;
    assign step     = r_busy && out_free;
    assign done     = step && (r_idx == SlotLast);
    assign o_ready  = !r_busy || done;
    assign load     = i_valid && o_ready;

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_char;
    assign o_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) r_out_valid <= step && r_keep[r_idx];
            if (load) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_char <= r_chars[r_idx];
            r_out_last <= (r_idx == SlotLast);
        end
        if (load) begin
            r_idx   <= i_slots.v4 ? SlotV4 : SlotV6;
            r_chars <= i_slots.chars;
            r_keep  <= i_slots.keep;
        end else if (step) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule
`default_nettype wire

[tb/peer_text_checker.sv]
`timescale 1ns / 100ps
// Checker for the socket peer text formatter: predicts and compares output words.
module peer_text_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_peer_valid,
    input  wire logic         i_peer_ready,
    // [31:0] ipv4_address, [63:32] ipv6_first_word, [95:64] ipv6_last_word,
    // [111:96] peer_port
    input  wire logic [111:0] i_peer_data,
    // [0] req_type
    input  wire logic         i_peer_user,
    input  wire logic         i_char_valid,
    input  wire logic         i_char_ready,
    // [7:0] text_char
    input  wire logic [7:0]   i_char_data,
    input  wire logic         i_char_last,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_peer_char;

    t_peer_char expected_chars_q[$];
    logic [7:0] text_buf[$];

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h61 + {4'd0, nib} - 8'd10);
    endfunction

    function automatic void append_decimal(input int unsigned value);
        logic [7:0]  digs[10];
        int          n;
        int unsigned rest;
        n    = 0;
        rest = value;
        if (rest == 0) begin
            text_buf.push_back(8'h30);
        end else begin
            while (rest > 0) begin
                digs[n] = 8'h30 + 8'(rest % 10);
                n++;
                rest = rest / 10;
            end
            while (n > 0) begin
                n--;
                text_buf.push_back(digs[n]);
            end
        end
    endfunction

    function automatic void append_hex_word(input logic [31:0] w);
        for (int i = 0; i < 8; i++) begin
            text_buf.push_back(hex_ascii(w[31 - 4 * i -: 4]));
        end
    endfunction

    function automatic void format_peer(input logic fam, input logic [111:0] d);
        logic [31:0] addr4;
        logic [31:0] first_word;
        logic [31:0] last_word;
        logic [15:0] port;
        addr4      = d[31:0];
        first_word = d[63:32];
        last_word  = d[95:64];
        port       = d[111:96];
        text_buf.delete();
        if (fam == spf_pkg::FamV4) begin
            for (int i = 3; i >= 0; i--) begin
                append_decimal(32'(addr4[8 * i +: 8]));
                if (i > 0) begin
                    text_buf.push_back(spf_pkg::ChDot);
                end
            end
            text_buf.push_back(spf_pkg::ChColon);
        end else begin
            text_buf.push_back(spf_pkg::ChOpen);
            append_hex_word(first_word);
            text_buf.push_back(spf_pkg::ChDot);
            text_buf.push_back(spf_pkg::ChDot);
            append_hex_word(last_word);
            text_buf.push_back(spf_pkg::ChClose);
            text_buf.push_back(spf_pkg::ChColon);
        end
        append_decimal(32'(port));
        for (int k = 0; k < text_buf.size(); k++) begin
            expected_chars_q.push_back('{text_buf[k], (k == text_buf.size() - 1)});
        end
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_peer_char head;
        if (i_rst_n) begin
            if (i_peer_valid && i_peer_ready) begin
                format_peer(i_peer_user, i_peer_data);
            end
            if (i_char_valid && i_char_ready) begin
                if (expected_chars_q.size() == 0) begin
                    $error("text_char expected none got %h", i_char_data);
                    o_fail_count++;
                end else begin
                    head = expected_chars_q.pop_front();
                    if (i_char_data !== head.ch) begin
                        $error("text_char expected %h got %h", head.ch, i_char_data);
                        o_fail_count++;
                    end
                    if (i_char_last !== head.last) begin
                        $error("last_char expected %0d got %0d", head.last, i_char_last);
                        o_fail_count++;
                    end
                end
            end
            o_pending = expected_chars_q.size();
        end else begin
            o_pending = 0;
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the socket peer text formatter: stimulus, flow control and verdict.
module tb_top;

    localparam int HoldCycles    = 400;
    localparam int WatchdogLimit = 4000;
    localparam int DrainCycles   = 64;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // [31:0] ipv4_address, [63:32] ipv6_first_word, [95:64] ipv6_last_word,
    // [111:96] peer_port
    logic [111:0] i_s_axis_tdata;
    // [0] req_type
    logic         i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // [7:0] text_char
    logic [7:0]   o_m_axis_tdata;
    logic         o_m_axis_tlast;

    int fail_count;
    int pending_chars;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    bit hold_req;

    socket_peer_text_formatter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    peer_text_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_peer_valid (i_s_axis_tvalid),
        .i_peer_ready (o_s_axis_tready),
        .i_peer_data  (i_s_axis_tdata),
        .i_peer_user  (i_s_axis_tuser),
        .i_char_valid (o_m_axis_tvalid),
        .i_char_ready (i_m_axis_tready),
        .i_char_data  (o_m_axis_tdata),
        .i_char_last  (o_m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_chars)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // hold off the receiver once on request, otherwise stall at random
    initial begin
        bit hold_done;
        hold_done       = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done       = 1'b1;
                i_m_axis_tready = 1'b0;
                repeat (HoldCycles - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
            || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_peer(input logic fam, input logic [31:0] addr4,
                             input logic [31:0] first_word, input logic [31:0] last_word,
                             input logic [15:0] port);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = fam;
        i_s_axis_tdata  = {port, last_word, first_word, addr4};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_octet();
        case ($urandom_range(3))
            0: return 8'($urandom_range(9));
            1: return 8'($urandom_range(99, 10));
            2: return 8'($urandom_range(255, 100));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_port();
        case ($urandom_range(5))
            0: return 16'($urandom_range(9));
            1: return 16'($urandom_range(99, 10));
            2: return 16'($urandom_range(999, 100));
            3: return 16'($urandom_range(9999, 1000));
            4: return 16'($urandom_range(65535, 10000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_peers(input int count);
        logic fam;
        for (int n = 0; n < count; n++) begin
            fam = ($urandom_range(1) == 0) ? spf_pkg::FamV4 : spf_pkg::FamV6;
            send_peer(fam, {rand_octet(), rand_octet(), rand_octet(), rand_octet()},
                      $urandom, $urandom, rand_port());
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_req        = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_peer(spf_pkg::FamV4, 32'h0000_0000, 32'h0, 32'h0, 16'd0);
        send_peer(spf_pkg::FamV4, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'd65535);
        send_peer(spf_pkg::FamV4, 32'h0a00_0001, 32'hdead_beef, 32'h1234_5678, 16'd80);
        send_peer(spf_pkg::FamV4, 32'h0116_8509, $urandom, $urandom, 16'd9);
        send_peer(spf_pkg::FamV4, 32'h640a_0100, $urandom, $urandom, 16'd10);
        send_peer(spf_pkg::FamV4, 32'hc763_09c8, $urandom, $urandom, 16'd99);
        send_peer(spf_pkg::FamV4, 32'h0850_fa07, $urandom, $urandom, 16'd100);
        send_peer(spf_pkg::FamV4, 32'h7f00_0001, $urandom, $urandom, 16'd999);
        send_peer(spf_pkg::FamV4, 32'hc0a8_0101, $urandom, $urandom, 16'd1000);
        send_peer(spf_pkg::FamV4, 32'hac10_fe03, $urandom, $urandom, 16'd9999);
        send_peer(spf_pkg::FamV4, 32'h0963_6dff, $urandom, $urandom, 16'd10000);
        send_peer(spf_pkg::FamV6, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd0);
        send_peer(spf_pkg::FamV6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'd65535);
        send_peer(spf_pkg::FamV6, $urandom, 32'h2001_0db8, 32'h0000_0001, 16'd443);
        send_peer(spf_pkg::FamV6, $urandom, 32'h0123_4567, 32'h89ab_cdef, 16'd8080);
        send_peer(spf_pkg::FamV6, $urandom, 32'hfe80_0000, 32'hdead_beef, 16'd1);

        // hold the receiver off and keep offering peers so that the input stalls
        hold_req = 1'b1;
        send_random_peers(16);
        send_random_peers(14);

        send_idle_pct  = 85;
        recv_stall_pct = 0;
        send_random_peers(25);

        send_idle_pct  = 0;
        recv_stall_pct = 85;
        send_random_peers(25);

        send_idle_pct  = 38;
        recv_stall_pct = 38;
        send_random_peers(25);

        i_s_axis_tvalid = 1'b0;
        wait (pending_chars == 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && pending_chars == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
